@@ hw/rtl/wdc_pkg.sv @@
// Whitespace dibit codec package: character codes, error codes and the
// command word passed from the front end to the back end.
// No dependencies.
`default_nettype none

package wdc_pkg;

  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam logic [1:0] ERR_OK         = 2'd0;
  localparam logic [1:0] ERR_INVALID    = 2'd1;
  localparam logic [1:0] ERR_INCOMPLETE = 2'd2;

  localparam logic [1:0] DIBIT_LAST = 2'd3;

  typedef struct packed {
    logic       enc;
    logic [7:0] data;
    logic [1:0] err;
    logic       eom;
  } cmd_t;

  typedef struct packed {
    logic       ok;
    logic [1:0] dibit;
  } dibit_t;

  function automatic logic [7:0] char_of_dibit(input logic [1:0] d);
    logic [7:0] c;
    case (d)
      2'd0:    c = CHAR_TAB;
      2'd1:    c = CHAR_LF;
      2'd2:    c = CHAR_CR;
      default: c = CHAR_SPACE;
    endcase
    return c;
  endfunction

  function automatic dibit_t dibit_of_char(input logic [7:0] c);
    dibit_t r;
    case (c)
      CHAR_TAB:   r = '{ok: 1'b1, dibit: 2'd0};
      CHAR_LF:    r = '{ok: 1'b1, dibit: 2'd1};
      CHAR_CR:    r = '{ok: 1'b1, dibit: 2'd2};
      CHAR_SPACE: r = '{ok: 1'b1, dibit: 2'd3};
      default:    r = '{ok: 1'b0, dibit: 2'd0};
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/whitespace_dibit_codec.sv @@
// Whitespace dibit codec top level: front end, command queue, back end.
// Depends on wdc_pkg, wdc_front, wdc_queue, wdc_back.
//
// Usage:
//   cfg channel writes the direction bit (0 encode, 1 decode); a write
//   also drops any partial decode group. cfg_ready is always high; write
//   only while no results are pending. in_tready drops during a write.
//   in channel: in_tdata is the byte or character, in_tlast marks the
//   last item of a message.
//   out channel: out_tdata is the character or byte (0 on error),
//   out_tlast the final result of its input item, out_tuser the error
//   code and the message-end flag.
// Throughput: one result per cycle from the back end while out_tready is
//   high, so an encoded byte gives four results and a decoded character
//   at most one. The front end accepts an item per cycle while the command
//   queue has room and cfg_valid is low, so input and output stall
//   independently.
// Reset: clears direction to encode, the decode group, the queue and the
//   output valid flag. A stalled out_tready holds the result steady; input
//   is refused once the queue fills.
`default_nettype none

module whitespace_dibit_codec #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_data,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] in_value
  input  wire logic       in_tlast,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_value
  output logic            out_tlast,
  output logic [2:0]      out_tuser   // [1:0] error_code, [2] message_end
);
  import wdc_pkg::*;

  cmd_t push_cmd, head;
  logic push, pop, empty, full;
  logic [1:0] err;
  logic eom;

  assign cfg_ready = 1'b1;
  assign in_tready = !full && !cfg_valid;
  assign out_tuser = {eom, err};

  wdc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_dir  (cfg_data),
    .in_fire  (in_tvalid && in_tready),
    .in_value (in_tdata),
    .in_eom   (in_tlast),
    .push     (push),
    .push_cmd (push_cmd)
  );

  wdc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  wdc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_value (out_tdata),
    .out_last  (out_tlast),
    .out_err   (err),
    .out_eom   (eom)
  );

endmodule

`default_nettype wire

@@ hw/rtl/wdc_front.sv @@
// Whitespace dibit codec front end: holds the direction register, accepts
// input items, tracks the decode group and pushes commands.
// Depends on wdc_pkg.
`default_nettype none

module wdc_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_we,
  input  wire logic         cfg_dir,
  input  wire logic         in_fire,
  input  wire logic [7:0]   in_value,
  input  wire logic         in_eom,
  output logic              push,
  output wdc_pkg::cmd_t     push_cmd
);
  import wdc_pkg::*;

  logic       dir_r, dir_nxt;
  logic [1:0] pos_r, pos_nxt;
  logic [5:0] part_r, part_nxt;
  dibit_t     dc;
  logic [5:0] part_add;

  always_comb begin
    dc       = dibit_of_char(in_value);
    part_add = part_r | (6'({4'd0, dc.dibit}) << {pos_r, 1'b0});
    dir_nxt  = dir_r;
    pos_nxt  = pos_r;
    part_nxt = part_r;
    push     = 1'b0;
    push_cmd = '{enc: 1'b0, data: 8'd0, err: ERR_OK, eom: in_eom};
    if (cfg_we) begin
      dir_nxt  = cfg_dir;
      pos_nxt  = 2'd0;
      part_nxt = 6'd0;
    end else if (in_fire) begin
      if (!dir_r) begin
        push          = 1'b1;
        push_cmd.enc  = 1'b1;
        push_cmd.data = in_value;
      end else if (!dc.ok) begin
        push         = 1'b1;
        push_cmd.err = ERR_INVALID;
        pos_nxt      = 2'd0;
        part_nxt     = 6'd0;
      end else if (pos_r == DIBIT_LAST) begin
        push          = 1'b1;
        push_cmd.data = {dc.dibit, part_r};
        pos_nxt       = 2'd0;
        part_nxt      = 6'd0;
      end else if (in_eom) begin
        push         = 1'b1;
        push_cmd.err = ERR_INCOMPLETE;
        pos_nxt      = 2'd0;
        part_nxt     = 6'd0;
      end else begin
        pos_nxt  = pos_r + 2'd1;
        part_nxt = part_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r  <= 1'b0;
      pos_r  <= 2'd0;
      part_r <= 6'd0;
    end else begin
      dir_r  <= dir_nxt;
      pos_r  <= pos_nxt;
      part_r <= part_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/wdc_queue.sv @@
// Whitespace dibit codec command queue: a small FIFO between front and back.
// Depends on wdc_pkg.
`default_nettype none

module wdc_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire wdc_pkg::cmd_t push_cmd,
  input  wire logic          pop,
  output wdc_pkg::cmd_t      head,
  output logic               empty,
  output logic               full
);
  import wdc_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          entries[DEPTH];
  logic [PW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  always_comb begin
    empty   = (cnt_r == CW'(0));
    full    = (cnt_r == CW'(DEPTH));
    head    = entries[rd_r];
    do_push = push && !full;
    do_pop  = pop && !empty;
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == PW'(DEPTH - 1)) ? PW'(0) : wr_r + PW'(1);
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PW'(DEPTH - 1)) ? PW'(0) : rd_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/wdc_back.sv @@
// Whitespace dibit codec back end: pops commands, expands encode commands
// into four characters and drives the registered result channel.
// Depends on wdc_pkg.
`default_nettype none

module wdc_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire wdc_pkg::cmd_t head,
  input  wire logic          empty,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [7:0]         out_value,
  output logic               out_last,
  output logic [1:0]         out_err,
  output logic               out_eom
);
  import wdc_pkg::*;

  cmd_t       cur_r, cur_nxt;
  logic       cur_vld_r, cur_vld_nxt;
  logic [1:0] beat_r, beat_nxt;
  logic       ov_r, ov_nxt;
  logic [7:0] oval_r, oval_nxt;
  logic       olast_r, olast_nxt;
  logic [1:0] oerr_r, oerr_nxt;
  logic       oeom_r, oeom_nxt;
  logic       out_free, emit, beat_last;
  logic [1:0] dibit;

  always_comb begin
    out_free    = !ov_r || out_ready;
    emit        = out_free && cur_vld_r;
    beat_last   = !cur_r.enc || (beat_r == DIBIT_LAST);
    dibit       = 2'(cur_r.data >> {beat_r, 1'b0});
    ov_nxt      = ov_r && !out_ready;
    oval_nxt    = oval_r;
    olast_nxt   = olast_r;
    oerr_nxt    = oerr_r;
    oeom_nxt    = oeom_r;
    cur_nxt     = cur_r;
    cur_vld_nxt = cur_vld_r;
    beat_nxt    = beat_r;
    if (emit) begin
      ov_nxt = 1'b1;
      if (cur_r.enc) begin
        oval_nxt  = char_of_dibit(dibit);
        olast_nxt = beat_last;
        oerr_nxt  = ERR_OK;
        oeom_nxt  = beat_last && cur_r.eom;
      end else begin
        oval_nxt  = cur_r.data;
        olast_nxt = 1'b1;
        oerr_nxt  = cur_r.err;
        oeom_nxt  = cur_r.eom;
      end
      if (beat_last) begin
        cur_vld_nxt = 1'b0;
      end else begin
        beat_nxt = beat_r + 2'd1;
      end
    end
    pop = !empty && (!cur_vld_r || (emit && beat_last));
    if (pop) begin
      cur_nxt     = head;
      cur_vld_nxt = 1'b1;
      beat_nxt    = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      beat_r    <= 2'd0;
      ov_r      <= 1'b0;
    end else begin
      cur_vld_r <= cur_vld_nxt;
      beat_r    <= beat_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    oval_r  <= oval_nxt;
    olast_r <= olast_nxt;
    oerr_r  <= oerr_nxt;
    oeom_r  <= oeom_nxt;
  end

  assign out_valid = ov_r;
  assign out_value = oval_r;
  assign out_last  = olast_r;
  assign out_err   = oerr_r;
  assign out_eom   = oeom_r;

endmodule

`default_nettype wire

@@ hw/rtl/wdc_checker.sv @@
// Whitespace dibit codec port checker and its bind to the top level.
// Depends on wdc_pkg.
`default_nettype none

module wdc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tlast,
  input wire logic [2:0] out_tuser
);
  import wdc_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] != ERR_OK |-> out_tdata == 8'd0 && out_tlast)
    else $error("error result not a single zero item");

  a_eom_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tlast)
    else $error("message end on a non-final result");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser[1:0] == ERR_OK || out_tuser[1:0] == ERR_INVALID ||
                   out_tuser[1:0] == ERR_INCOMPLETE)
    else $error("undefined error code");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind whitespace_dibit_codec wdc_checker u_wdc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

`default_nettype wire
